### design/brrd_pkg.sv
// Shared types and constants for the raster run-length row decoder.
// Used by the result queue and the top level; no dependencies.
package brrd_pkg;

    // Clamp limits applied to the configured image size
    localparam logic [14:0] MAX_WIDTH  = 15'd16384;
    localparam logic [14:0] MAX_HEIGHT = 15'd16384;

    // Longest row-number varint, in bytes
    localparam logic [2:0] ROW_VARINT_MAX = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DEPTH  = 2'd2;

    // Result kinds
    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Final status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC_RUN = 2'd1;
    localparam logic [1:0] ST_FEW_ROWS  = 2'd2;

    // One result transaction
    typedef struct packed {
        logic        kind;
        logic [13:0] row;
        logic [13:0] xs;
        logic [14:0] len;
        logic [6:0]  color;
        logic [1:0]  status;
        logic [14:0] rows;
        logic        last;
    } result_t;

endpackage

### design/brrd_out_queue.sv
// Three-entry result queue between the decoder and the output channel.
// Takes up to two results a cycle, shows one at its head. Uses brrd_pkg.
module brrd_out_queue
    import brrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   push_n,
    input  result_t      push_d0,
    input  result_t      push_d1,
    output logic         near_full,
    output logic         head_valid,
    output result_t      head,
    input  logic         head_stall
);

    result_t     q_reg [3];
    result_t     q_next [3];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [1:0]  cnt_after;
    logic        pop;

    assign head_valid = (count_reg != 2'd0);
    assign head       = q_reg[0];
    assign pop        = head_valid && !head_stall;
    // Fewer than two free entries: no new byte may be taken
    assign near_full  = (count_reg > 2'd1);

    // Shift down on pop, then append new results behind the survivors
    always_comb
    begin
        cnt_after = count_reg - {1'b0, pop};
        for (int i = 0; i < 3; i++)
        begin
            if (pop && i < 2)
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
            if (push_n != 2'd0 && 2'(i) == cnt_after)
                q_next[i] = push_d0;
            if (push_n == 2'd2 && 2'(i) == cnt_after + 2'd1)
                q_next[i] = push_d1;
        end
        count_next = cnt_after + push_n;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // No overflow: pushes only land in free entries
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (3'(count_reg) - 3'(pop) + 3'(push_n)) <= 3'd3)
        else $error("result queue overflow");

    // No double push while fewer than two entries are free
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (count_reg <= 2'd1))
        else $error("double push without room");

    // Two or more held results always hold off the input
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= 2'd2) |-> near_full)
        else $error("input not stalled with queue near full");

endmodule

### design/bsb_raster_rle_row_decoder_unit.sv
// Run-length raster row decoder: one raster byte in, run descriptors and a
// final status out. Uses brrd_pkg and brrd_out_queue.
// Results are registered in the result queue before they reach the output.
// Throughput: one byte per cycle; the three-entry result queue stalls input
// only while it holds two or more results (one byte can cause two).
// Reset: asynchronous, active low; decoder returns to expecting the depth byte,
// registers to width 1, height 1, depth 7; queue empties.
module bsb_raster_rle_row_decoder_unit
    import brrd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [14:0]  cfg_data,
    // byte input
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   data_byte,
    input  logic         end_of_stream,
    // result output
    output logic         out_valid,
    input  logic         out_stall,
    output logic         result_kind,
    output logic [13:0]  row_index,
    output logic [13:0]  x_start,
    output logic [14:0]  run_length,
    output logic [6:0]   pixel_color,
    output logic [1:0]   decode_status,
    output logic [14:0]  rows_done,
    output logic         last_of_item
);

    typedef enum logic [2:0] {
        PH_DEPTH,
        PH_ROWNUM,
        PH_RUN,
        PH_CONT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    // configuration registers
    logic [14:0] width_reg;
    logic [14:0] height_reg;
    logic [2:0]  hdr_depth_reg;

    // decoder state
    phase_t      phase_reg, phase_next;
    logic [2:0]  depth_reg, depth_next;
    logic [31:0] row_acc_reg, row_acc_next;
    logic [2:0]  vbytes_reg, vbytes_next;
    logic [14:0] cur_row_reg, cur_row_next;
    logic [14:0] x_reg, x_next;
    logic [31:0] run_acc_reg, run_acc_next;
    logic [6:0]  color_reg, color_next;
    logic [14:0] rows_reg, rows_next;

    // datapath
    logic        in_acc;
    logic [14:0] eff_w, eff_h;
    logic [2:0]  cnt_width;
    logic [7:0]  cnt_sel;
    logic [7:0]  col_sel;
    logic [6:0]  byte_color;
    logic        do_finish;
    logic [31:0] fin_acc;
    logic [6:0]  fin_color;
    logic [14:0] avail;
    logic [14:0] len;
    logic [14:0] x_end;
    logic        emit_run;
    logic [31:0] row_shift;
    logic [2:0]  vb_inc;
    logic [14:0] rows_inc;
    logic [14:0] rows_fin;
    logic [14:0] need;
    logic [1:0]  status;

    result_t     run_res, stat_res, push_d0;
    logic [1:0]  push_n;
    logic        near_full;
    result_t     head;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = near_full;

    // Effective size and field split for the active depth
    assign eff_w      = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    assign eff_h      = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    assign cnt_width  = 3'd7 - depth_reg;
    assign cnt_sel    = (8'd1 << cnt_width) - 8'd1;
    assign col_sel    = (8'd1 << depth_reg) - 8'd1;
    assign byte_color = 7'((data_byte >> cnt_width) & col_sel);
    assign row_shift  = {row_acc_reg[24:0], data_byte[6:0]};
    assign vb_inc     = vbytes_reg + 3'd1;
    assign rows_inc   = rows_reg + 15'd1;
    assign need       = (eff_h < 15'd2) ? eff_h : 15'd2;

    // Run completion: clip to row end
    always_comb
    begin
        do_finish = 1'b0;
        fin_acc   = run_acc_reg;
        fin_color = color_reg;
        if (phase_reg == PH_RUN)
        begin
            do_finish = (data_byte != 8'd0) && !data_byte[7];
            fin_acc   = {24'd0, data_byte & cnt_sel};
            fin_color = byte_color;
        end
        else if (phase_reg == PH_CONT)
        begin
            do_finish = !data_byte[7];
            fin_acc   = {run_acc_reg[24:0], data_byte[6:0]};
        end
        avail    = (x_reg >= eff_w) ? 15'd0 : (eff_w - x_reg);
        len      = (fin_acc >= {17'd0, avail}) ? avail : (fin_acc[14:0] + 15'd1);
        x_end    = x_reg + len;
        emit_run = do_finish && (cur_row_reg < eff_h) && (len != 15'd0);
    end

    // Per-byte state update
    always_comb
    begin
        phase_next   = phase_reg;
        depth_next   = depth_reg;
        row_acc_next = row_acc_reg;
        vbytes_next  = vbytes_reg;
        cur_row_next = cur_row_reg;
        x_next       = x_reg;
        run_acc_next = run_acc_reg;
        color_next   = color_reg;
        rows_next    = rows_reg;

        case (phase_reg)
            PH_DEPTH:
            begin
                depth_next   = (data_byte inside {[8'd1:8'd7]}) ? data_byte[2:0]
                                                                : hdr_depth_reg;
                row_acc_next = 32'd0;
                vbytes_next  = 3'd0;
                phase_next   = (rows_reg >= eff_h) ? PH_DONE : PH_ROWNUM;
            end
            PH_ROWNUM:
            begin
                row_acc_next = row_shift;
                vbytes_next  = vb_inc;
                if (!data_byte[7])
                begin
                    if (row_shift == 32'd0 || {1'b0, row_shift} > {18'd0, eff_h} + 33'd1)
                        phase_next = PH_DONE;
                    else
                    begin
                        cur_row_next = 15'(row_shift - 32'd1);
                        x_next       = 15'd0;
                        phase_next   = PH_RUN;
                    end
                end
                else if (vb_inc >= ROW_VARINT_MAX)
                    phase_next = PH_DONE;
            end
            PH_RUN, PH_CONT, PH_SKIP:
            begin
                if (phase_reg != PH_CONT && data_byte == 8'd0)
                begin
                    // end of row
                    rows_next    = rows_inc;
                    row_acc_next = 32'd0;
                    vbytes_next  = 3'd0;
                    phase_next   = (rows_inc >= eff_h) ? PH_DONE : PH_ROWNUM;
                end
                else if (phase_reg != PH_SKIP)
                begin
                    run_acc_next = fin_acc;
                    color_next   = fin_color;
                    if (do_finish)
                    begin
                        x_next     = x_end;
                        phase_next = (x_end >= eff_w) ? PH_SKIP : PH_RUN;
                    end
                    else
                        phase_next = PH_CONT;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Final status on the last byte
    always_comb
    begin
        rows_fin = rows_next;
        if (phase_next == PH_RUN || phase_next == PH_SKIP)
            rows_fin = rows_next + 15'd1;
        if (phase_next == PH_CONT)
            status = ST_TRUNC_RUN;
        else if (rows_fin < need)
            status = ST_FEW_ROWS;
        else
            status = ST_OK;
    end

    // Result assembly
    always_comb
    begin
        run_res        = '0;
        run_res.kind   = KIND_RUN;
        run_res.row    = cur_row_reg[13:0];
        run_res.xs     = x_reg[13:0];
        run_res.len    = len;
        run_res.color  = fin_color;
        run_res.last   = !end_of_stream;

        stat_res        = '0;
        stat_res.kind   = KIND_STATUS;
        stat_res.status = status;
        stat_res.rows   = rows_fin;
        stat_res.last   = 1'b1;

        push_d0 = emit_run ? run_res : stat_res;
        push_n  = 2'd0;
        if (in_acc)
            push_n = 2'({1'b0, emit_run} + {1'b0, end_of_stream});
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 15'd1;
            height_reg    <= 15'd1;
            hdr_depth_reg <= 3'd7;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg     <= cfg_data;
                CFG_HEIGHT: height_reg    <= cfg_data;
                CFG_DEPTH:  hdr_depth_reg <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    // Decoder state; the last byte returns everything to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_DEPTH;
            depth_reg   <= 3'd0;
            row_acc_reg <= 32'd0;
            vbytes_reg  <= 3'd0;
            cur_row_reg <= 15'd0;
            x_reg       <= 15'd0;
            run_acc_reg <= 32'd0;
            color_reg   <= 7'd0;
            rows_reg    <= 15'd0;
        end
        else if (in_acc)
        begin
            if (end_of_stream)
            begin
                phase_reg   <= PH_DEPTH;
                depth_reg   <= 3'd0;
                row_acc_reg <= 32'd0;
                vbytes_reg  <= 3'd0;
                cur_row_reg <= 15'd0;
                x_reg       <= 15'd0;
                run_acc_reg <= 32'd0;
                color_reg   <= 7'd0;
                rows_reg    <= 15'd0;
            end
            else
            begin
                phase_reg   <= phase_next;
                depth_reg   <= depth_next;
                row_acc_reg <= row_acc_next;
                vbytes_reg  <= vbytes_next;
                cur_row_reg <= cur_row_next;
                x_reg       <= x_next;
                run_acc_reg <= run_acc_next;
                color_reg   <= color_next;
                rows_reg    <= rows_next;
            end
        end
    end

    brrd_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push_d0    (push_d0),
        .push_d1    (stat_res),
        .near_full  (near_full),
        .head_valid (out_valid),
        .head       (head),
        .head_stall (out_stall)
    );

    assign result_kind   = head.kind;
    assign row_index     = head.row;
    assign x_start       = head.xs;
    assign run_length    = head.len;
    assign pixel_color   = head.color;
    assign decode_status = head.status;
    assign rows_done     = head.rows;
    assign last_of_item  = head.last;

    // Last byte of a section leaves the decoder waiting for a depth byte
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && end_of_stream) |=> (phase_reg == PH_DEPTH && rows_reg == 15'd0))
        else $error("state not cleared after end of stream");

    // Two results from one byte only when it ends the stream
    a_two_needs_eos: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (in_acc && end_of_stream && emit_run))
        else $error("two results without end of stream");

    // A stalled result transaction holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(head)))
        else $error("stalled result changed");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench for bsb_raster_rle_row_decoder_unit: raster sections go in as bytes, and every run
// descriptor and final status coming out is checked against a decoder model.
// Depends on brrd_pkg and the design files; needs nothing else.
module tb
    import brrd_pkg::*;
();

    // Decoder phases of the model
    typedef enum logic [2:0] {
        DEC_DEPTH,
        DEC_ROWNUM,
        DEC_RUN,
        DEC_CONT,
        DEC_SKIP,
        DEC_DONE
    } dec_phase_t;

    // Row decoder model plus the queue of run descriptors and statuses still due
    class rle_row_model;
        logic [14:0] cfg_width;
        logic [14:0] cfg_height;
        logic [2:0]  cfg_depth;
        dec_phase_t  ph;
        logic [2:0]  depth;
        logic [31:0] row_acc;
        logic [2:0]  vbytes;
        logic [14:0] cur_row;
        logic [14:0] x_pos;
        logic [31:0] run_acc;
        logic [6:0]  color;
        logic [14:0] rows_dec;
        result_t     fresh[$];
        result_t     due[$];
        int          mismatches;
        int          runs_checked;
        int          status_checked;

        function new();
            cfg_width = 15'd1;
            cfg_height = 15'd1;
            cfg_depth = 3'd7;
            mismatches = 0;
            runs_checked = 0;
            status_checked = 0;
            clear();
        endfunction

        function void clear();
            ph = DEC_DEPTH;
            depth = '0;
            row_acc = '0;
            vbytes = '0;
            cur_row = '0;
            x_pos = '0;
            run_acc = '0;
            color = '0;
            rows_dec = '0;
        endfunction

        function logic [14:0] w_eff();
            return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        endfunction

        function logic [14:0] h_eff();
            return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [14:0] val);
            case (idx)
                CFG_WIDTH:  cfg_width = val;
                CFG_HEIGHT: cfg_height = val;
                CFG_DEPTH:  cfg_depth = val[2:0];
                default:    ;
            endcase
        endfunction

        function void next_row_number();
            row_acc = '0;
            vbytes = '0;
            ph = (rows_dec >= h_eff()) ? DEC_DONE : DEC_ROWNUM;
        endfunction

        function void end_row();
            rows_dec = rows_dec + 15'd1;
            next_row_number();
        endfunction

        // Clip the run to the row, emit it if it fills pixels, advance x
        function void close_run();
            logic [32:0] len;
            logic [32:0] avail;
            logic [14:0] w;
            result_t     r;
            w = w_eff();
            len = {1'b0, run_acc} + 33'd1;
            avail = (x_pos >= w) ? 33'd0 : 33'(w - x_pos);
            if (len > avail)
                len = avail;
            if (cur_row < h_eff() && len != 33'd0)
            begin
                r = '0;
                r.kind = KIND_RUN;
                r.row = cur_row[13:0];
                r.xs = x_pos[13:0];
                r.len = len[14:0];
                r.color = color;
                fresh = {fresh, r};
            end
            x_pos = x_pos + len[14:0];
            ph = (x_pos >= w) ? DEC_SKIP : DEC_RUN;
        endfunction

        // One accepted byte: update state and queue what it causes
        function void take_byte(logic [7:0] c, logic eos);
            logic [2:0]  cbits;
            logic [6:0]  cmask;
            logic [6:0]  kmask;
            logic [14:0] need;
            logic [1:0]  st;
            result_t     r;
            cbits = 3'd7 - depth;
            cmask = 7'((8'd1 << depth) - 8'd1);
            kmask = 7'((8'd1 << cbits) - 8'd1);
            fresh.delete();
            case (ph)
                DEC_DEPTH:
                begin
                    depth = (c >= 8'd1 && c <= 8'd7) ? c[2:0] : cfg_depth;
                    next_row_number();
                end
                DEC_ROWNUM:
                begin
                    row_acc = {row_acc[24:0], c[6:0]};
                    vbytes = vbytes + 3'd1;
                    if (!c[7])
                    begin
                        if (row_acc == 32'd0 ||
                            {1'b0, row_acc} > {18'd0, h_eff()} + 33'd1)
                            ph = DEC_DONE;
                        else
                        begin
                            cur_row = row_acc[14:0] - 15'd1;
                            x_pos = '0;
                            ph = DEC_RUN;
                        end
                    end
                    else if (vbytes >= ROW_VARINT_MAX)
                        ph = DEC_DONE;
                end
                DEC_RUN:
                begin
                    if (c == 8'd0)
                        end_row();
                    else
                    begin
                        color = 7'(c >> cbits) & cmask;
                        run_acc = {25'd0, c[6:0] & kmask};
                        if (c[7])
                            ph = DEC_CONT;
                        else
                            close_run();
                    end
                end
                DEC_CONT:
                begin
                    run_acc = {run_acc[24:0], c[6:0]};
                    if (!c[7])
                        close_run();
                end
                DEC_SKIP:
                begin
                    if (c == 8'd0)
                        end_row();
                end
                default: ;
            endcase

            // Final status; an open row counts unless a run is cut short
            if (eos)
            begin
                need = (h_eff() < 15'd2) ? h_eff() : 15'd2;
                if (ph == DEC_CONT)
                    st = ST_TRUNC_RUN;
                else
                begin
                    if (ph == DEC_RUN || ph == DEC_SKIP)
                        rows_dec = rows_dec + 15'd1;
                    st = (rows_dec < need) ? ST_FEW_ROWS : ST_OK;
                end
                r = '0;
                r.kind = KIND_STATUS;
                r.status = st;
                r.rows = rows_dec;
                fresh = {fresh, r};
                clear();
            end

            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                due = {due, fresh[i]};
        endfunction

        function void cmp(string fname, int unsigned e, int unsigned a);
            if (e != a)
            begin
                $display("%0t ns: %s expected %0d got %0d", $time, fname, e, a);
                mismatches++;
            end
        endfunction

        // One accepted result against the oldest one due
        function void match_result(result_t got);
            result_t e;
            if (due.size() == 0)
            begin
                $display("%0t ns: unexpected result, kind %0d, nothing due",
                         $time, got.kind);
                mismatches++;
                return;
            end
            e = due.pop_front();
            cmp("result_kind", e.kind, got.kind);
            cmp("row_index", e.row, got.row);
            cmp("x_start", e.xs, got.xs);
            cmp("run_length", e.len, got.len);
            cmp("pixel_color", e.color, got.color);
            cmp("decode_status", e.status, got.status);
            cmp("rows_done", e.rows, got.rows);
            cmp("last_of_item", e.last, got.last);
            if (e.kind == KIND_RUN)
                runs_checked++;
            else
                status_checked++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        out_valid;
    logic        out_stall;
    logic        result_kind;
    logic [13:0] row_index;
    logic [13:0] x_start;
    logic [14:0] run_length;
    logic [6:0]  pixel_color;
    logic [1:0]  decode_status;
    logic [14:0] rows_done;
    logic        last_of_item;

    bsb_raster_rle_row_decoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .row_index     (row_index),
        .x_start       (x_start),
        .run_length    (run_length),
        .pixel_color   (pixel_color),
        .decode_status (decode_status),
        .rows_done     (rows_done),
        .last_of_item  (last_of_item)
    );

    rle_row_model row_model = new();
    logic [7:0]   sec_bytes[$];
    int unsigned  bytes_sent;
    int unsigned  sections_sent;
    int           cur_w;
    int           cur_h;
    bit           in_quiet;

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Transactions on both channels, sampled before the edge updates anything
    always @(posedge clk)
    begin : watch
        result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                row_model.take_byte(data_byte, end_of_stream);
            if (out_valid && !out_stall)
            begin
                got.kind = result_kind;
                got.row = row_index;
                got.xs = x_start;
                got.len = run_length;
                got.color = pixel_color;
                got.status = decode_status;
                got.rows = rows_done;
                got.last = last_of_item;
                row_model.match_result(got);
            end
        end
    end

    // Result side back-pressure, with quiet stretches
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 9) < 2)
                repeat ($urandom_range(10, 80))
                begin
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            else
            begin
                repeat (pick_gap())
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
                repeat ($urandom_range(1, 4))
                begin
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic eos);
        int g;
        g = in_quiet ? 0 : pick_gap();
        repeat (g)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_stream <= eos;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic send_section();
        foreach (sec_bytes[i])
            send_byte(sec_bytes[i], i == sec_bytes.size() - 1);
        bytes_sent += sec_bytes.size();
        sections_sent++;
    endtask

    // Drop valid, drain all results, let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (row_model.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        row_model.set_reg(idx, val);
    endtask

    task automatic configure(int w, int h, logic [14:0] d_word);
        write_reg(CFG_WIDTH, 15'(w));
        write_reg(CFG_HEIGHT, 15'(h));
        write_reg(CFG_DEPTH, d_word);
        cur_w = w;
        cur_h = h;
    endtask

    // Append one byte to the section being built
    function automatic void add_byte(logic [7:0] b);
        sec_bytes = {sec_bytes, b};
    endfunction

    // Row number as a 7-bit varint, optionally led by zero groups
    function automatic void add_rownum(longint unsigned v, int pad);
        logic [6:0]      grp[$];
        longint unsigned t;
        t = v;
        do
        begin
            grp.push_front(7'(t & 64'h7F));
            t = t >> 7;
        end
        while (t != 0);
        repeat (pad) add_byte(8'h80);
        foreach (grp[i])
            add_byte({i != grp.size() - 1, grp[i]});
    endfunction

    // Run byte, sometimes with continuation bytes; never a row end
    function automatic void add_run();
        logic [6:0] body;
        logic       top;
        int         n;
        top = ($urandom_range(0, 3) == 0);
        body = 7'($urandom_range(0, 127));
        if (!top && body == 7'd0)
            body = 7'd1;
        add_byte({top, body});
        if (top)
        begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                add_byte({k != n - 1, 7'($urandom_range(0, 127))});
        end
    endfunction

    // Section with random content, bad row numbers included, and a random kind of ending
    function automatic void build_section();
        int              nrows;
        int              hh;
        int              r;
        longint unsigned rn;
        sec_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 80)
            add_byte(8'($urandom_range(1, 7)));
        else if (r < 90)
            add_byte(8'h00);
        else
            add_byte(8'($urandom_range(8, 255)));
        hh = (cur_h > 16384) ? 16384 : cur_h;
        nrows = $urandom_range(0, ((hh < 4) ? hh : 4) + 1);
        for (int i = 1; i <= nrows; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                rn = i;
            else if (r < 80)
                rn = hh + 1;
            else if (r < 85)
                rn = 0;
            else if (r < 90)
                rn = $urandom;
            else
                rn = $urandom_range(1, hh + 2);
            add_rownum(rn, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
            repeat ($urandom_range(0, 6)) add_run();
            if ($urandom_range(0, 19) != 0)
                add_byte(8'h00);
        end
        r = $urandom_range(0, 99);
        if (r < 15)
            add_byte({1'b1, 7'($urandom_range(0, 127))});
        else if (r < 25)
            repeat ($urandom_range(1, 3)) add_run();
        else if (r < 30)
            add_byte(8'h80 | 8'($urandom_range(0, 127)));
    endfunction

    // Random bytes with plenty of zeros
    function automatic void build_noise();
        sec_bytes.delete();
        repeat ($urandom_range(1, 16))
            add_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
    endfunction

    function automatic int pick_dim(int small_hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        else if (r < 18)
        begin
            case ($urandom_range(0, 3))
                0: return 1;
                1: return 16384;
                2: return 16385;
                default: return 32767;
            endcase
        end
        return $urandom_range(1, small_hi);
    endfunction

    // Main sequence
    initial
    begin
        int phase_no;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        end_of_stream = 1'b0;
        in_quiet = 1'b0;
        bytes_sent = 0;
        sections_sent = 0;
        cur_w = 1;
        cur_h = 1;
        phase_no = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: header depth from an out-of-range depth byte,
        // a long count clipped to one pixel, bytes after the last row
        sec_bytes = '{8'h00, 8'h01, 8'hFF, 8'hFF, 8'h05, 8'h00, 8'h33};
        send_section();
        // Row zero stops decoding: too few rows
        sec_bytes = '{8'h09, 8'h00, 8'h12};
        send_section();
        // Row number varint that never ends
        sec_bytes = '{8'h02, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
        send_section();
        settle();

        // Zero width, zero header depth: row height+1, zero-length runs
        configure(0, 2, 15'd0);
        sec_bytes = '{8'h00, 8'h03, 8'h05, 8'h00, 8'h02, 8'h10, 8'h00, 8'h80};
        send_section();
        settle();

        // Largest size: stream ends inside a run
        configure(16384, 16384, 15'd5);
        sec_bytes = '{8'h03, 8'h01, 8'h85};
        send_section();

        // Random phases, each with its own register setting
        while (bytes_sent < 1350)
        begin
            settle();
            case (phase_no)
                0: configure(32767, 32767, {12'($urandom), 3'd7});
                1: configure(16384, 16384, {12'($urandom), 3'd1});
                default: configure(pick_dim(40), pick_dim(6),
                                   {12'($urandom), 3'($urandom_range(0, 7))});
            endcase
            repeat ($urandom_range(2, 6))
            begin
                in_quiet = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 4) == 0)
                    build_noise();
                else
                    build_section();
                send_section();
            end
            phase_no++;
        end
        settle();

        $display("%0d raster bytes in %0d sections over %0d register settings",
                 bytes_sent, sections_sent, phase_no + 3);
        $display("%0d run descriptors and %0d final statuses compared",
                 row_model.runs_checked, row_model.status_checked);
        if (row_model.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("%0t ns: timed out, %0d results outstanding", $time, row_model.pending());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
design/brrd_pkg.sv
design/brrd_out_queue.sv
design/bsb_raster_rle_row_decoder_unit.sv
dv/tb.sv
